>>> design/adsr_pkg.sv
// Shared types, widths and constants of the ADSR envelope shaper
package adsr_pkg;

  // field and register widths
  localparam int LEN_W      = 21;
  localparam int LVL_W      = 15;
  localparam int SMP_W      = 16;
  localparam int PH_W       = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 21;

  // default upper bound of the sample counter
  localparam int MAX_SAMPLES_DEF = 1048576;

  // shared divider geometry: 57-bit dividend, 42-bit divisor, 16 quotient bits
  localparam int DIV_DVD_W = 57;
  localparam int DIV_DSR_W = 42;
  localparam int DIV_Q_W   = 16;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_ENV_MODE      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ATTACK_LEN    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DECAY_END     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RELEASE_START = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TOTAL_LEN     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PEAK_LEVEL    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SUSTAIN_LEVEL = 3'd6;

  // register values after reset
  localparam logic             ENV_MODE_RST      = 1'b0;
  localparam logic [LEN_W-1:0] ATTACK_LEN_RST    = 21'd441;
  localparam logic [LEN_W-1:0] DECAY_END_RST     = 21'd20286;
  localparam logic [LEN_W-1:0] RELEASE_START_RST = 21'd39690;
  localparam logic [LEN_W-1:0] TOTAL_LEN_RST     = 21'd44100;
  localparam logic [LVL_W-1:0] PEAK_LEVEL_RST    = 15'd32767;
  localparam logic [LVL_W-1:0] SUSTAIN_LEVEL_RST = 15'd16383;

  // envelope phase reported with each result
  typedef enum logic [PH_W-1:0] {
    PH_ATTACK  = 3'd0,
    PH_DECAY   = 3'd1,
    PH_SUSTAIN = 3'd2,
    PH_HOLD    = 3'd3,
    PH_RELEASE = 3'd4,
    PH_END     = 3'd5
  } phase_t;

  // controller states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL1,
    ST_MUL2,
    ST_DSTART1,
    ST_DWAIT1,
    ST_GMUL,
    ST_DSTART2,
    ST_DWAIT2,
    ST_EMIT
  } ctrl_state_t;

  // datapath commands
  typedef enum logic [2:0] {
    DP_NOP,
    DP_LOAD,
    DP_MUL1,
    DP_MUL2,
    DP_DIV,
    DP_GAIN,
    DP_GMUL,
    DP_EMIT
  } dp_op_t;

  // datapath status seen by the controller
  typedef struct packed {
    phase_t phase;
    logic   peak_zero;
    logic   div_done;
  } dp_status_t;

endpackage

>>> design/adsr_envelope_shaper_core.sv
// Top level of the ADSR envelope shaper: controller plus datapath
//
// Shapes a stream of signed 16-bit samples with an attack/decay/sustain/
// hold/release envelope, one result beat per input beat, counting the
// sample index from the last beat flagged first_of_note. Gains are exact
// integer ratios truncated toward zero and results saturate to 16 bits.
// One beat is worked on at a time; the output register lets the next beat
// be taken while a result still waits. The shared 16-step divider is used
// once in attack and sustain, twice in decay and release and not at all
// past the end of the note or on the hold sample; a zero peak level skips
// its last use outside attack. Registers are written through the plain
// write port; the user must write them only while the block is idle, which
// the block itself does not enforce.
module adsr_envelope_shaper_core import adsr_pkg::*; #(
  parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_write,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic signed [SMP_W-1:0] sample_in,
  input  logic                    first_of_note,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [SMP_W-1:0] sample_out,
  output logic [PH_W-1:0]         phase
);

  dp_op_t     op;
  dp_status_t status;

  adsr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .op        (op)
  );

  adsr_dp #(
    .MAX_SAMPLES (MAX_SAMPLES)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .sample_in     (sample_in),
    .first_of_note (first_of_note),
    .op            (op),
    .status        (status),
    .sample_out    (sample_out),
    .phase         (phase)
  );

endmodule

>>> design/adsr_div.sv
// Shared restoring divider, one quotient bit per cycle, with overflow flag
module adsr_div import adsr_pkg::*; #(
  parameter int DVD_W = DIV_DVD_W,
  parameter int DSR_W = DIV_DSR_W,
  parameter int Q_W   = DIV_Q_W
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DSR_W-1:0] divisor,
  output logic [Q_W-1:0]   quotient,
  output logic             ovf,
  output logic             done
);

  localparam int CNT_W = $clog2(Q_W + 1);

  logic [DSR_W-1:0] rem;
  logic [Q_W-1:0]   low;
  logic [DSR_W-1:0] sor;
  logic [CNT_W-1:0] cnt;
  logic             busy;

  logic [DSR_W:0]   trial;
  logic [DSR_W:0]   trial_diff;
  logic             fits;

  // one trial subtraction per step
  assign trial      = {rem, low[Q_W-1]};
  assign trial_diff = trial - {1'b0, sor};
  assign fits       = (trial >= {1'b0, sor});
  assign quotient   = low;

  // step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(Q_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // partial remainder and quotient shift register
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= DSR_W'(dividend >> Q_W);
      low <= dividend[Q_W-1:0];
      sor <= divisor;
      ovf <= ((dividend >> Q_W) >= DVD_W'(divisor));
    end else if (busy) begin
      rem <= fits ? trial_diff[DSR_W-1:0] : trial[DSR_W-1:0];
      low <= {low[Q_W-2:0], fits};
    end
  end

endmodule

>>> design/adsr_dp.sv
// Datapath: registers, sample counter, phase decode, multipliers and divider
module adsr_dp import adsr_pkg::*; #(
  parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_write,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data,
  input  logic signed [SMP_W-1:0] sample_in,
  input  logic                    first_of_note,
  input  dp_op_t                  op,
  output dp_status_t              status,
  output logic signed [SMP_W-1:0] sample_out,
  output logic [PH_W-1:0]         phase
);

  localparam int IDX_W  = $clog2(MAX_SAMPLES + 1);
  localparam int CMP_W  = (IDX_W > LEN_W) ? IDX_W : LEN_W;
  localparam int PROD_W = 2 * LEN_W;
  localparam int GP_W   = SMP_W + LVL_W;
  localparam logic [SMP_W-1:0] POS_MAX = {1'b0, {(SMP_W-1){1'b1}}};
  localparam logic [SMP_W-1:0] NEG_MAG = {1'b1, {(SMP_W-1){1'b0}}};

  // configuration registers
  logic             env_mode;
  logic [LEN_W-1:0] attack_len;
  logic [LEN_W-1:0] decay_end;
  logic [LEN_W-1:0] release_start;
  logic [LEN_W-1:0] total_len;
  logic [LVL_W-1:0] peak_level;
  logic [LVL_W-1:0] sustain_level;

  // state kept across beats
  logic [IDX_W-1:0]        sample_index;
  logic signed [SMP_W-1:0] previous_output;

  // per-item working registers
  logic [SMP_W-1:0]     x_mag;
  logic                 x_neg;
  logic [LEN_W-1:0]     t_cur;
  phase_t               phase_q;
  logic [DIV_DVD_W-1:0] p1;
  logic [DIV_DSR_W-1:0] dsor;
  logic [LVL_W-1:0]     gain;

  // divider outputs
  logic [DIV_Q_W-1:0] quot;
  logic               div_ovf;
  logic               div_done;

  // combinational terms
  logic [IDX_W-1:0]        idx_now;
  logic [IDX_W-1:0]        idx_adv;
  logic [CMP_W-1:0]        t_ext;
  phase_t                  phase_new;
  logic [SMP_W-1:0]        in_u;
  logic [SMP_W-1:0]        x_mag_new;
  logic [LEN_W-1:0]        t_minus_a;
  logic [LEN_W-1:0]        rem_len;
  logic [LEN_W-1:0]        span;
  logic                    diff_neg;
  logic [LVL_W-1:0]        diff_mag;
  logic [LEN_W-1:0]        mul_a;
  logic [LEN_W-1:0]        mul_b;
  logic [PROD_W-1:0]       prod1;
  logic [PROD_W-1:0]       span_sq;
  logic [PROD_W-1:0]       sor_m1;
  logic [LVL_W-1:0]        base;
  logic [DIV_DVD_W-1:0]    prod2;
  logic [GP_W-1:0]         gprod;
  logic [SMP_W-1:0]        gain_sum;
  logic signed [SMP_W-1:0] y_q;
  logic signed [SMP_W-1:0] y_new;

  // index for this beat and phase decode, first match wins
  assign idx_now = first_of_note ? '0 : sample_index;
  assign idx_adv = (idx_now < IDX_W'(MAX_SAMPLES)) ? idx_now + 1'b1 : idx_now;
  assign t_ext   = CMP_W'(idx_now);

  always_comb begin
    priority if (t_ext >= CMP_W'(total_len)) begin
      phase_new = PH_END;
    end else if (t_ext < CMP_W'(attack_len)) begin
      phase_new = PH_ATTACK;
    end else if (!env_mode) begin
      phase_new = PH_RELEASE;
    end else if (t_ext < CMP_W'(decay_end)) begin
      phase_new = PH_DECAY;
    end else if (t_ext < CMP_W'(release_start)) begin
      phase_new = PH_SUSTAIN;
    end else if (t_ext == CMP_W'(release_start)) begin
      phase_new = PH_HOLD;
    end else begin
      phase_new = PH_RELEASE;
    end
  end

  // sample magnitude and sign
  assign in_u      = sample_in;
  assign x_mag_new = in_u[SMP_W-1] ? (~in_u + 1'b1) : in_u;

  // first multiply: ramp numerator or remaining length squared
  assign t_minus_a = t_cur - attack_len;
  assign rem_len   = total_len - t_cur;
  assign span      = env_mode ? (total_len - release_start) : (total_len - attack_len);
  assign diff_neg  = (sustain_level > peak_level);
  assign diff_mag  = diff_neg ? (sustain_level - peak_level) : (peak_level - sustain_level);

  always_comb begin
    unique case (phase_q)
      PH_ATTACK: begin
        mul_a  = t_cur;
        mul_b  = LEN_W'(x_mag);
        sor_m1 = PROD_W'(attack_len);
      end
      PH_DECAY: begin
        mul_a  = t_minus_a;
        mul_b  = LEN_W'(diff_mag);
        sor_m1 = PROD_W'(decay_end - attack_len);
      end
      default: begin
        mul_a  = rem_len;
        mul_b  = rem_len;
        sor_m1 = span_sq;
      end
    endcase
  end

  assign prod1   = mul_a * mul_b;
  assign span_sq = span * span;

  // second multiply: level times remaining length squared
  assign base  = env_mode ? sustain_level : peak_level;
  assign prod2 = base * p1[PROD_W-1:0];

  // gain multiply
  assign gprod = x_mag * gain;

  // decay gain: peak minus the signed ramp term
  assign gain_sum = diff_neg ? ({1'b0, peak_level} + quot) : ({1'b0, peak_level} - quot);

  // signed, saturated quotient
  always_comb begin
    if (x_neg) begin
      if (div_ovf || (quot > NEG_MAG)) begin
        y_q = NEG_MAG;
      end else begin
        y_q = ~quot + 1'b1;
      end
    end else begin
      if (div_ovf || (quot > POS_MAX)) begin
        y_q = POS_MAX;
      end else begin
        y_q = quot;
      end
    end
  end

  always_comb begin
    unique case (phase_q)
      PH_END:    y_new = '0;
      PH_HOLD:   y_new = previous_output;
      PH_ATTACK: y_new = y_q;
      default:   y_new = (peak_level == '0) ? '0 : y_q;
    endcase
  end

  // configuration writes, counter and last output
  always_ff @(posedge clk) begin
    if (rst) begin
      env_mode        <= ENV_MODE_RST;
      attack_len      <= ATTACK_LEN_RST;
      decay_end       <= DECAY_END_RST;
      release_start   <= RELEASE_START_RST;
      total_len       <= TOTAL_LEN_RST;
      peak_level      <= PEAK_LEVEL_RST;
      sustain_level   <= SUSTAIN_LEVEL_RST;
      sample_index    <= '0;
      previous_output <= '0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          REG_ENV_MODE:      env_mode      <= cfg_data[0];
          REG_ATTACK_LEN:    attack_len    <= cfg_data[LEN_W-1:0];
          REG_DECAY_END:     decay_end     <= cfg_data[LEN_W-1:0];
          REG_RELEASE_START: release_start <= cfg_data[LEN_W-1:0];
          REG_TOTAL_LEN:     total_len     <= cfg_data[LEN_W-1:0];
          REG_PEAK_LEVEL:    peak_level    <= cfg_data[LVL_W-1:0];
          REG_SUSTAIN_LEVEL: sustain_level <= cfg_data[LVL_W-1:0];
          default: ;
        endcase
      end
      if (op == DP_LOAD) begin
        sample_index <= idx_adv;
      end
      if (op == DP_EMIT) begin
        previous_output <= y_new;
      end
    end
  end

  // working registers, stepped by the controller
  always_ff @(posedge clk) begin
    unique case (op)
      DP_LOAD: begin
        x_mag   <= x_mag_new;
        x_neg   <= in_u[SMP_W-1];
        t_cur   <= t_ext[LEN_W-1:0];
        phase_q <= phase_new;
      end
      DP_MUL1: begin
        p1   <= DIV_DVD_W'(prod1);
        dsor <= sor_m1;
        gain <= sustain_level;
      end
      DP_MUL2: begin
        p1 <= prod2;
      end
      DP_GAIN: begin
        gain <= (phase_q == PH_DECAY) ? gain_sum[LVL_W-1:0] : quot[LVL_W-1:0];
      end
      DP_GMUL: begin
        p1   <= DIV_DVD_W'(gprod);
        dsor <= DIV_DSR_W'(peak_level);
      end
      DP_EMIT: begin
        sample_out <= y_new;
        phase      <= phase_q;
      end
      default: ;
    endcase
  end

  adsr_div #(
    .DVD_W (DIV_DVD_W),
    .DSR_W (DIV_DSR_W),
    .Q_W   (DIV_Q_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (op == DP_DIV),
    .dividend (p1),
    .divisor  (dsor),
    .quotient (quot),
    .ovf      (div_ovf),
    .done     (div_done)
  );

  assign status.phase     = phase_q;
  assign status.peak_zero = (peak_level == '0);
  assign status.div_done  = div_done;

endmodule

>>> design/adsr_ctrl.sv
// Controller: sequences one beat through multiply, divide and output stages
module adsr_ctrl import adsr_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  output logic       out_valid,
  input  logic       out_stall,
  input  dp_status_t status,
  output dp_op_t     op
);

  ctrl_state_t state;
  ctrl_state_t state_next;
  logic        out_valid_next;

  // state and output valid registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  // next state and datapath command
  always_comb begin
    state_next     = state;
    op             = DP_NOP;
    out_valid_next = out_valid && out_stall;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          op         = DP_LOAD;
          state_next = ST_MUL1;
        end
      end
      ST_MUL1: begin
        unique case (status.phase)
          PH_END, PH_HOLD: begin
            state_next = ST_EMIT;
          end
          PH_SUSTAIN: begin
            op         = DP_MUL1;
            state_next = ST_GMUL;
          end
          PH_RELEASE: begin
            op         = DP_MUL1;
            state_next = ST_MUL2;
          end
          default: begin
            op         = DP_MUL1;
            state_next = ST_DSTART1;
          end
        endcase
      end
      ST_MUL2: begin
        op         = DP_MUL2;
        state_next = ST_DSTART1;
      end
      ST_DSTART1: begin
        op         = DP_DIV;
        state_next = ST_DWAIT1;
      end
      ST_DWAIT1: begin
        if (status.div_done) begin
          if (status.phase == PH_ATTACK) begin
            state_next = ST_EMIT;
          end else begin
            op         = DP_GAIN;
            state_next = ST_GMUL;
          end
        end
      end
      ST_GMUL: begin
        if (status.peak_zero) begin
          state_next = ST_EMIT;
        end else begin
          op         = DP_GMUL;
          state_next = ST_DSTART2;
        end
      end
      ST_DSTART2: begin
        op         = DP_DIV;
        state_next = ST_DWAIT2;
      end
      ST_DWAIT2: begin
        if (status.div_done) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        // load the output register once it is free or being taken
        if (!out_valid || !out_stall) begin
          op             = DP_EMIT;
          out_valid_next = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign in_stall = rst || (state != ST_IDLE);

endmodule

>>> design/adsr_checker.sv
// Port-level checks of the ADSR envelope shaper and their bind
module adsr_checker import adsr_pkg::*; (
  input logic                    clk,
  input logic                    rst,
  input logic                    in_valid,
  input logic                    in_stall,
  input logic                    out_valid,
  input logic                    out_stall,
  input logic signed [SMP_W-1:0] sample_out,
  input logic [PH_W-1:0]         phase
);

  // a held result beat stays put
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(sample_out) && $stable(phase))
    else $error("result beat changed while stalled");

  // past the end of the note the output is silent
  a_end_silent: assert property (@(posedge clk) disable iff (rst)
    out_valid && (phase == PH_END) |-> (sample_out == '0))
    else $error("non-zero sample past end of note");

  // one beat at a time: busy right after taking a beat
  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while previous beat still in work");

endmodule

bind adsr_envelope_shaper_core adsr_checker u_adsr_checker (.*);

>>> tb/tb_top.sv
// Self-checking testbench of the ADSR envelope shaper core
module tb_top;
  import adsr_pkg::*;

  localparam int SETTLE_CYCLES = 50;
  localparam int HOLD_CYCLES   = 400;
  localparam int IDLE_LIMIT    = 4000;
  localparam int REPORT_MAX    = 10;

  typedef struct {
    logic signed [SMP_W-1:0] smp;
    phase_t                  ph;
  } shaped_t;

  logic                    clk;
  logic                    rst;
  logic                    cfg_write;
  logic [CFG_IDX_W-1:0]    cfg_index;
  logic [CFG_DATA_W-1:0]   cfg_data;
  logic                    in_valid;
  logic                    in_stall;
  logic signed [SMP_W-1:0] sample_in;
  logic                    first_of_note;
  logic                    out_valid;
  logic                    out_stall;
  logic signed [SMP_W-1:0] sample_out;
  logic [PH_W-1:0]         phase;

  // envelope settings and note state as the shaper should hold them
  longint env_mode_cur = ENV_MODE_RST;
  longint attack_cur   = ATTACK_LEN_RST;
  longint decay_cur    = DECAY_END_RST;
  longint release_cur  = RELEASE_START_RST;
  longint total_cur    = TOTAL_LEN_RST;
  longint peak_cur     = PEAK_LEVEL_RST;
  longint sustain_cur  = SUSTAIN_LEVEL_RST;
  longint note_idx     = 0;
  longint last_shaped  = 0;

  shaped_t shaped_q[$];
  shaped_t want;
  int      mismatches  = 0;
  int      idle_cycles = 0;
  int      burst_left  = 0;

  // receiver stall pattern and long hold-off
  bit       hold_req = 1'b0;
  bit       hold_ack;
  int       hold_left;
  int       pat_left;
  logic [1:0] pat_mode;

  adsr_envelope_shaper_core u_top (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .sample_in     (sample_in),
    .first_of_note (first_of_note),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .sample_out    (sample_out),
    .phase         (phase)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ratio remain^2 / span^2 of a level, truncated
  function automatic longint quad_ratio(input longint base, input longint remain,
                                        input longint span);
    longint unsigned b;
    longint unsigned r;
    longint unsigned s;
    b = base;
    r = remain;
    s = span;
    return longint'((b * r * r) / (s * s));
  endfunction

  // apply gain g relative to the peak, saturating to 16 bits
  function automatic longint scale(input longint x, input longint g);
    longint v;
    if (peak_cur == 0) return 0;
    v = (x * g) / peak_cur;
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  // envelope of one sample beat; advances the note index
  function automatic shaped_t shape_sample(input logic signed [SMP_W-1:0] x, input logic first);
    shaped_t res;
    longint  xs;
    longint  t;
    longint  y;
    longint  q;
    phase_t  ph;
    xs = x;
    if (first) note_idx = 0;
    t = note_idx;
    if (t >= total_cur) begin
      y = 0;
      ph = PH_END;
    end else if (t < attack_cur) begin
      y = (xs * t) / attack_cur;
      ph = PH_ATTACK;
    end else if (env_mode_cur == 0) begin
      y = scale(xs, quad_ratio(peak_cur, total_cur - t, total_cur - attack_cur));
      ph = PH_RELEASE;
    end else if (t < decay_cur) begin
      q = ((t - attack_cur) * (peak_cur - sustain_cur)) / (decay_cur - attack_cur);
      y = scale(xs, peak_cur - q);
      ph = PH_DECAY;
    end else if (t < release_cur) begin
      y = scale(xs, sustain_cur);
      ph = PH_SUSTAIN;
    end else if (t == release_cur) begin
      y = last_shaped;
      ph = PH_HOLD;
    end else begin
      y = scale(xs, quad_ratio(sustain_cur, total_cur - t, total_cur - release_cur));
      ph = PH_RELEASE;
    end
    last_shaped = y;
    if (note_idx < MAX_SAMPLES_DEF) note_idx++;
    res.smp = y[SMP_W-1:0];
    res.ph = ph;
    return res;
  endfunction

  // result checker, sampled mid-cycle
  always @(negedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (shaped_q.size() == 0) begin
        if (mismatches < REPORT_MAX)
          $display("unexpected result beat: sample_out %0d phase %0d", sample_out, phase);
        mismatches++;
      end else begin
        want = shaped_q.pop_front();
        if (sample_out !== want.smp || phase !== want.ph) begin
          if (mismatches < REPORT_MAX)
            $display("mismatch: sample_out %0d expected %0d, phase %0d expected %0d",
                     sample_out, want.smp, phase, want.ph);
          mismatches++;
        end
      end
    end
  end

  // watchdog on cycles with no beat moving
  always @(negedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // receiver stall: random patterns, plus a long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      hold_ack <= 1'b0;
      hold_left <= 0;
      pat_left <= 0;
      pat_mode <= 2'd0;
    end else if (hold_req != hold_ack) begin
      hold_ack <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      if (pat_left == 0) begin
        pat_mode <= 2'($urandom_range(0, 3));
        pat_left <= $urandom_range(16, 160);
      end else begin
        pat_left <= pat_left - 1;
      end
      case (pat_mode)
        2'd0: out_stall <= 1'b0;
        2'd1: out_stall <= ($urandom_range(0, 3) == 0);
        2'd2: out_stall <= ($urandom_range(0, 3) != 0);
        default: out_stall <= ~out_stall;
      endcase
    end
  end

  // send one sample beat and wait until it is taken
  task automatic send_sample(input logic signed [SMP_W-1:0] x, input logic first);
    bit took;
    in_valid <= 1'b1;
    sample_in <= x;
    first_of_note <= first;
    do begin
      @(negedge clk);
      took = !in_stall;
      @(posedge clk);
    end while (!took);
    shaped_q.insert(shaped_q.size(), shape_sample(x, first));
  endtask

  // sender in bursts with random gaps between them
  task automatic offer(input logic signed [SMP_W-1:0] x, input logic first);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    send_sample(x, first);
  endtask

  // stop sending and wait until every result beat is back
  task automatic drain();
    in_valid <= 1'b0;
    burst_left = 0;
    while (shaped_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    case (idx)
      REG_ENV_MODE:      env_mode_cur = data[0];
      REG_ATTACK_LEN:    attack_cur = data[LEN_W-1:0];
      REG_DECAY_END:     decay_cur = data[LEN_W-1:0];
      REG_RELEASE_START: release_cur = data[LEN_W-1:0];
      REG_TOTAL_LEN:     total_cur = data[LEN_W-1:0];
      REG_PEAK_LEVEL:    peak_cur = data[LVL_W-1:0];
      REG_SUSTAIN_LEVEL: sustain_cur = data[LVL_W-1:0];
      default: ;
    endcase
  endtask

  // full register set, written once the block is idle; spare bits get junk
  task automatic configure(input bit mode, input int unsigned a, input int unsigned d,
                           input int unsigned r, input int unsigned tl,
                           input int unsigned p, input int unsigned s);
    logic [CFG_DATA_W-1:0] junk;
    drain();
    junk = CFG_DATA_W'($urandom);
    write_reg(REG_ENV_MODE, {junk[CFG_DATA_W-1:1], mode});
    write_reg(REG_ATTACK_LEN, a[LEN_W-1:0]);
    write_reg(REG_DECAY_END, d[LEN_W-1:0]);
    write_reg(REG_RELEASE_START, r[LEN_W-1:0]);
    write_reg(REG_TOTAL_LEN, tl[LEN_W-1:0]);
    junk = CFG_DATA_W'($urandom);
    write_reg(REG_PEAK_LEVEL, {junk[CFG_DATA_W-1:LVL_W], p[LVL_W-1:0]});
    junk = CFG_DATA_W'($urandom);
    write_reg(REG_SUSTAIN_LEVEL, {junk[CFG_DATA_W-1:LVL_W], s[LVL_W-1:0]});
    cfg_write <= 1'b0;
  endtask

  function automatic int unsigned pick_len();
    case ($urandom_range(0, 5))
      0: return 0;
      1: return 1;
      2: return MAX_SAMPLES_DEF;
      3: return (1 << LEN_W) - 1;
      4: return $urandom_range(0, (1 << LEN_W) - 1);
      default: return $urandom_range(0, 48);
    endcase
  endfunction

  function automatic logic signed [SMP_W-1:0] rand_sample();
    case ($urandom_range(0, 11))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return '0;
      3: return '1;
      default: return SMP_W'($urandom_range(0, 65535));
    endcase
  endfunction

  // mostly ordered boundaries on short notes, sometimes anything the fields allow
  task automatic random_config();
    int unsigned a, d, r, tl, p, s;
    bit mode;
    mode = 1'($urandom_range(0, 1));
    tl = $urandom_range(1, 48);
    a = $urandom_range(0, tl);
    d = $urandom_range(a, tl);
    r = $urandom_range(d, tl);
    case ($urandom_range(0, 9))
      0: begin
        a = pick_len();
        d = pick_len();
        r = pick_len();
        tl = pick_len();
      end
      1: tl = pick_len();
      default: ;
    endcase
    if ($urandom_range(0, 7) == 0) p = $urandom_range(0, 1) ? 0 : 32767;
    else p = $urandom_range(1, 32767);
    s = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 32767) : p / 2;
    configure(mode, a, d, r, tl, p, s);
  endtask

  // one note: an optional restart beat then a run of samples, with the odd stray restart
  task automatic play_note(input int len, input bit restart);
    bit first;
    for (int i = 0; i < len; i++) begin
      first = (i == 0 && restart) || ($urandom_range(0, 39) == 0);
      offer(rand_sample(), first);
    end
  endtask

  // attack with the values left by reset
  task automatic test_reset_values();
    send_sample(16'sh8000, 1'b1);
    send_sample(16'sh7fff, 1'b0);
    send_sample('1, 1'b0);
  endtask

  // linear attack, quadratic release, past end
  task automatic test_attack_release();
    configure(1'b0, 2, 0, 0, 5, 32767, 16383);
    send_sample(16'sh7fff, 1'b1);
    send_sample(16'sh8000, 1'b0);
    send_sample(16'sh7fff, 1'b0);
    send_sample(16'sh8000, 1'b0);
    send_sample(16'sd12345, 1'b0);
    send_sample(16'sd100, 1'b0);
  endtask

  // every phase of the full envelope in one short note
  task automatic test_full_adsr();
    configure(1'b1, 1, 3, 4, 6, 20000, 10000);
    send_sample(16'sh7fff, 1'b1);
    send_sample(16'sh8000, 1'b0);
    send_sample(16'sh7fff, 1'b0);
    send_sample(-16'sd5000, 1'b0);
    send_sample(16'sd1, 1'b0);
    send_sample(16'sh8000, 1'b0);
    send_sample(16'sh7fff, 1'b0);
  endtask

  // zero peak silences sustain, hold and release
  task automatic test_zero_peak();
    configure(1'b1, 0, 0, 1, 3, 0, 16383);
    send_sample(16'sh7fff, 1'b1);
    send_sample(16'sh8000, 1'b0);
    send_sample(16'sh7fff, 1'b0);
  endtask

  // sustain far above peak: negative decay term and saturation
  task automatic test_sustain_over_peak();
    configure(1'b1, 0, 2, 3, 4, 1, 32767);
    send_sample(16'sh7fff, 1'b1);
    send_sample(16'sh8000, 1'b0);
    send_sample(16'sh7fff, 1'b0);
    send_sample(16'sh8000, 1'b0);
  endtask

  // decay end before attack end: decay phase skipped
  task automatic test_boundary_order();
    configure(1'b1, 1, 0, 2, 4, 32767, 16383);
    send_sample(16'sh7fff, 1'b1);
    send_sample(16'sh8000, 1'b0);
    send_sample(16'sh7fff, 1'b0);
    send_sample(16'sh8000, 1'b0);
  endtask

  // widest lengths: huge release span and huge decay span
  task automatic test_extreme_lengths();
    configure(1'b0, 0, 0, 0, (1 << LEN_W) - 1, 32767, 0);
    send_sample(16'sh7fff, 1'b1);
    send_sample(16'sh8000, 1'b0);
    configure(1'b1, 0, (1 << LEN_W) - 1, (1 << LEN_W) - 1, MAX_SAMPLES_DEF, 32767, 0);
    send_sample(16'sh8000, 1'b1);
    send_sample(16'sh7fff, 1'b0);
  endtask

  // long receiver hold-off while the sender keeps offering, then a full drain
  task automatic test_backpressure();
    configure(1'b1, 4, 10, 20, 30, 30000, 15000);
    hold_req <= ~hold_req;
    for (int i = 0; i < 32; i++) send_sample(rand_sample(), i == 0);
    drain();
  endtask

  task automatic test_random_notes(input int n_settings, input int per_setting);
    int sent;
    int len;
    for (int k = 0; k < n_settings; k++) begin
      random_config();
      sent = 0;
      while (sent < per_setting) begin
        len = (total_cur <= 64) ? int'(total_cur) + $urandom_range(1, 3) : $urandom_range(1, 64);
        play_note(len, $urandom_range(0, 7) != 0);
        sent += len;
      end
    end
  endtask

  // test sequence
  initial begin
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    sample_in = '0;
    first_of_note = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    test_reset_values();
    test_attack_release();
    test_full_adsr();
    test_zero_peak();
    test_sustain_over_peak();
    test_boundary_order();
    test_extreme_lengths();
    test_backpressure();
    test_random_notes(40, 24);
    drain();

    if (mismatches == 0 && shaped_q.size() == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule

>>> adsr_envelope_shaper_core.f
design/adsr_pkg.sv
design/adsr_div.sv
design/adsr_dp.sv
design/adsr_ctrl.sv
design/adsr_envelope_shaper_core.sv
design/adsr_checker.sv
tb/tb_top.sv
